// ===== hw/rtl/ffn_pkg.sv =====
// Shared constants and types for the flat face normal pipeline.
`default_nettype none
package ffn_pkg;
    localparam int COORD_WIDTH_DEF  = 24;
    localparam int NORMAL_FRAC_DEF  = 14;
    localparam int EDGE_W           = 32;
    localparam int MAG_W            = 63;
    localparam int NRM_W            = 31;
    localparam int SUM_W            = 64;
    localparam int ROOT_W           = 32;
    localparam int OUT_W            = 16;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
        logic       last;
    } t_side;
endpackage
`default_nettype wire

// ===== hw/rtl/ffn_cross.sv =====
// Edge differences, edge reduction, cross product and component magnitudes.
`default_nettype none
module ffn_cross import ffn_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_last,
    input  logic [8:0][COORD_WIDTH-1:0]   i_corner,
    output logic                          o_valid,
    output logic [2:0][MAG_W-1:0]         o_mag,
    output t_side                         o_side
);
    localparam int EW = COORD_WIDTH + 1;
    localparam int MW = (EW > 31) ? EW : 31;

    logic [3:0]                r_v;
    logic [2:0]                r_last;
    logic signed [EW-1:0]      r_e [6];
    logic signed [EW-1:0]      n_e [6];
    logic [EDGE_W-1:0]         r_r [6];
    logic [EDGE_W-1:0]         n_r [6];
    logic signed [63:0]        r_p [6];
    logic signed [63:0]        n_p [6];
    logic [MW-1:0]             w_mag [6];
    logic [MW-1:0]             w_or;
    logic [1:0]                w_s;
    logic signed [63:0]        w_d [3];
    logic [2:0][MAG_W-1:0]     r_mag;
    logic [2:0]                r_neg;
    logic                      r_olast;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_e[i]     = EW'($signed(i_corner[i])) - EW'($signed(i_corner[3+i]));
            n_e[3 + i] = EW'($signed(i_corner[3+i])) - EW'($signed(i_corner[6+i]));
        end
    end

    always_comb begin
        logic signed [MW:0] ex;
        logic [MW-1:0]      sh;
        w_or = '0;
        for (int i = 0; i < 6; i++) begin
            ex       = (MW+1)'(r_e[i]);
            w_mag[i] = ex[MW] ? MW'(-ex) : MW'(ex);
            w_or     = w_or | w_mag[i];
        end
        w_s = 2'd0;
        for (int k = 31; k < MW; k++) begin
            if (w_or[k]) begin
                w_s = 2'(k - 30);
            end
        end
        for (int i = 0; i < 6; i++) begin
            sh     = w_mag[i] >> w_s;
            n_r[i] = r_e[i][EW-1] ? EDGE_W'(-{1'b0, sh[30:0]}) : EDGE_W'({1'b0, sh[30:0]});
        end
    end

    always_comb begin
        n_p[0] = $signed(r_r[1]) * $signed(r_r[5]);
        n_p[1] = $signed(r_r[2]) * $signed(r_r[4]);
        n_p[2] = $signed(r_r[2]) * $signed(r_r[3]);
        n_p[3] = $signed(r_r[0]) * $signed(r_r[5]);
        n_p[4] = $signed(r_r[0]) * $signed(r_r[4]);
        n_p[5] = $signed(r_r[1]) * $signed(r_r[3]);
        w_d[0] = r_p[0] - r_p[1];
        w_d[1] = r_p[2] - r_p[3];
        w_d[2] = r_p[4] - r_p[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last  <= {r_last[1:0], i_last};
            r_olast <= r_last[2];
            for (int i = 0; i < 6; i++) begin
                r_e[i] <= n_e[i];
                r_r[i] <= n_r[i];
                r_p[i] <= n_p[i];
            end
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= w_d[i][63] ? MAG_W'(-w_d[i]) : MAG_W'(w_d[i]);
                r_neg[i] <= w_d[i][63];
            end
        end
    end

    assign o_valid      = r_v[3];
    assign o_mag        = r_mag;
    assign o_side.neg   = r_neg;
    assign o_side.degen = 1'b0;
    assign o_side.last  = r_olast;
endmodule
`default_nettype wire

// ===== hw/rtl/ffn_norm.sv =====
// Block normalisation of the cross product and sum of squares.
`default_nettype none
module ffn_norm import ffn_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [2:0][MAG_W-1:0]     i_mag,
    input  t_side                     i_side,
    output logic                      o_valid,
    output logic [2:0][NRM_W-1:0]     o_mag,
    output logic [SUM_W-1:0]          o_sum,
    output t_side                     o_side
);
    logic [3:0]               r_v;
    t_side                    r_side [4];
    t_side                    n_side;
    logic [2:0][MAG_W-1:0]    r_m;
    logic [5:0]               r_pos;
    logic [5:0]               n_pos;
    logic [MAG_W-1:0]         w_or;
    logic [2:0][NRM_W-1:0]    r_n;
    logic [2:0][NRM_W-1:0]    n_n;
    logic [2:0][NRM_W-1:0]    r_n2;
    logic [2:0][NRM_W-1:0]    r_n3;
    logic [61:0]              r_sq [3];
    logic [SUM_W-1:0]         r_sum;

    always_comb begin
        w_or  = i_mag[0] | i_mag[1] | i_mag[2];
        n_pos = 6'd0;
        for (int k = 0; k < MAG_W; k++) begin
            if (w_or[k]) begin
                n_pos = 6'(k);
            end
        end
        n_side       = i_side;
        n_side.degen = (w_or == '0);
    end

    always_comb begin
        logic [MAG_W-1:0] sh;
        for (int i = 0; i < 3; i++) begin
            if (r_pos >= 6'd31) begin
                sh = r_m[i] >> (r_pos - 6'd30);
            end else begin
                sh = r_m[i] << (6'd30 - r_pos);
            end
            n_n[i] = sh[NRM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k < 4; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_m   <= i_mag;
            r_pos <= n_pos;
            r_n   <= n_n;
            r_n2  <= r_n;
            r_n3  <= r_n2;
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= 62'(r_n[i]) * 62'(r_n[i]);
            end
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        end
    end

    assign o_valid = r_v[3];
    assign o_mag   = r_n3;
    assign o_sum   = r_sum;
    assign o_side  = r_side[3];
endmodule
`default_nettype wire

// ===== hw/rtl/ffn_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module ffn_sqrt import ffn_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [SUM_W-1:0]          i_sum,
    input  logic [2:0][NRM_W-1:0]     i_mag,
    input  t_side                     i_side,
    output logic                      o_valid,
    output logic [ROOT_W-1:0]         o_len,
    output logic [2:0][NRM_W-1:0]     o_mag,
    output t_side                     o_side
);
    localparam int REM_W = ROOT_W + 3;
    localparam int NST   = ROOT_W + 1;

    logic [NST-1:0]           r_v;
    logic [SUM_W-1:0]         r_rad  [NST];
    logic [REM_W-1:0]         r_rem  [NST];
    logic [ROOT_W-1:0]        r_root [NST];
    logic [2:0][NRM_W-1:0]    r_mag  [NST];
    t_side                    r_side [NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_sum;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_mag[0]  <= i_mag;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < ROOT_W; g++) begin : g_step
        logic [REM_W-1:0]  w_rs;
        logic [REM_W-1:0]  w_t;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        always_comb begin
            w_rs = {r_rem[g][REM_W-3:0], r_rad[g][SUM_W-1 -: 2]};
            w_t  = REM_W'({r_root[g], 2'b01});
            if (w_rs >= w_t) begin
                n_rem  = w_rs - w_t;
                n_root = {r_root[g][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = w_rs;
                n_root = {r_root[g][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[g+1]  <= {r_rad[g][SUM_W-3:0], 2'b00};
                r_rem[g+1]  <= n_rem;
                r_root[g+1] <= n_root;
                r_mag[g+1]  <= r_mag[g];
                r_side[g+1] <= r_side[g];
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_len   = r_root[NST-1];
    assign o_mag   = r_mag[NST-1];
    assign o_side  = r_side[NST-1];
endmodule
`default_nettype wire

// ===== hw/rtl/ffn_div.sv =====
// Pipelined rounded division of each component by the length, and the output register.
`default_nettype none
module ffn_div import ffn_pkg::*; #(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [ROOT_W-1:0]         i_len,
    input  logic [2:0][NRM_W-1:0]     i_mag,
    input  t_side                     i_side,
    output logic                      o_valid,
    output logic [2:0][OUT_W-1:0]     o_normal,
    output logic                      o_degen,
    output logic                      o_last
);
    localparam int QW    = NORMAL_FRAC_BITS + 1;
    localparam int NW    = NRM_W + NORMAL_FRAC_BITS + 1;
    localparam int RW    = ROOT_W + 1;
    localparam int SW    = (NORMAL_FRAC_BITS + 3 > OUT_W + 1) ? NORMAL_FRAC_BITS + 3 : OUT_W + 1;
    localparam int NST   = QW + 1;

    logic [NST-1:0]           r_v;
    logic [NW-1:0]            r_num  [NST][3];
    logic [RW-1:0]            r_rem  [NST][3];
    logic [QW-1:0]            r_q    [NST][3];
    logic [ROOT_W-1:0]        r_d    [NST];
    t_side                    r_side [NST];
    logic [NW-1:0]            n_num  [3];
    logic                     r_ov;
    logic [2:0][OUT_W-1:0]    r_normal;
    logic [2:0][OUT_W-1:0]    n_normal;
    logic                     r_degen;
    logic                     r_last;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = NW'({i_mag[i], {NORMAL_FRAC_BITS{1'b0}}}) + NW'(i_len >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[NST-2:0], i_valid};
            r_ov <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d[0]    <= i_len;
            r_side[0] <= i_side;
            for (int i = 0; i < 3; i++) begin
                r_num[0][i] <= n_num[i];
                r_rem[0][i] <= RW'(n_num[i][NW-1:QW]);
                r_q[0][i]   <= '0;
            end
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [RW-1:0] w_rs [3];
        logic [RW-1:0] n_rem [3];
        logic [QW-1:0] n_q [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                w_rs[i] = {r_rem[g][i][RW-2:0], r_num[g][i][QW-1-g]};
                if (w_rs[i] >= RW'(r_d[g])) begin
                    n_rem[i] = w_rs[i] - RW'(r_d[g]);
                    n_q[i]   = {r_q[g][i][QW-2:0], 1'b1};
                end else begin
                    n_rem[i] = w_rs[i];
                    n_q[i]   = {r_q[g][i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[g+1]    <= r_d[g];
                r_side[g+1] <= r_side[g];
                for (int i = 0; i < 3; i++) begin
                    r_num[g+1][i] <= r_num[g][i];
                    r_rem[g+1][i] <= n_rem[i];
                    r_q[g+1][i]   <= n_q[i];
                end
            end
        end
    end

    always_comb begin
        logic signed [SW-1:0] sv;
        for (int i = 0; i < 3; i++) begin
            sv = r_side[NST-1].neg[i] ? -SW'(r_q[NST-1][i]) : SW'(r_q[NST-1][i]);
            if (r_side[NST-1].degen) begin
                n_normal[i] = '0;
            end else if (sv > SW'(32767)) begin
                n_normal[i] = 16'sd32767;
            end else if (sv < -SW'(32768)) begin
                n_normal[i] = 16'h8000;
            end else begin
                n_normal[i] = sv[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_normal <= n_normal;
            r_degen  <= r_side[NST-1].degen;
            r_last   <= r_side[NST-1].last;
        end
    end

    assign o_valid  = r_ov;
    assign o_normal = r_normal;
    assign o_degen  = r_degen;
    assign o_last   = r_last;
endmodule
`default_nettype wire

// ===== hw/rtl/flat_face_normal_top.sv =====
// Top level of the flat face normal pipeline.
// Throughput: one face per cycle unless stalled; each stage and multiplier output is registered.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
// Reset is synchronous and active low; it clears the valid bits only.
`default_nettype none
module flat_face_normal_top import ffn_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // corner0_x, corner0_y, corner0_z, corner1_x .. corner2_z, zero fill
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    input  logic                                    i_s_axis_tlast,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // normal_x, normal_y, normal_z
    output logic [3*OUT_W-1:0]                      o_m_axis_tdata,
    // degenerate
    output logic                                    o_m_axis_tuser,
    output logic                                    o_m_axis_tlast
);
    logic                      w_en;
    logic [8:0][COORD_WIDTH-1:0] w_corner;
    logic                      w_cv;
    logic [2:0][MAG_W-1:0]     w_cmag;
    t_side                     w_cside;
    logic                      w_nv;
    logic [2:0][NRM_W-1:0]     w_nmag;
    logic [SUM_W-1:0]          w_sum;
    t_side                     w_nside;
    logic                      w_sv;
    logic [ROOT_W-1:0]         w_len;
    logic [2:0][NRM_W-1:0]     w_smag;
    t_side                     w_sside;
    logic [2:0][OUT_W-1:0]     w_normal;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_corner        = i_s_axis_tdata[9*COORD_WIDTH-1:0];

    ffn_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(i_s_axis_tvalid), .i_last(i_s_axis_tlast), .i_corner(w_corner),
        .o_valid(w_cv), .o_mag(w_cmag), .o_side(w_cside)
    );

    ffn_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_cv), .i_mag(w_cmag), .i_side(w_cside),
        .o_valid(w_nv), .o_mag(w_nmag), .o_sum(w_sum), .o_side(w_nside)
    );

    ffn_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_nv), .i_sum(w_sum), .i_mag(w_nmag), .i_side(w_nside),
        .o_valid(w_sv), .o_len(w_len), .o_mag(w_smag), .o_side(w_sside)
    );

    ffn_div #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_valid(w_sv), .i_len(w_len), .i_mag(w_smag), .i_side(w_sside),
        .o_valid(o_m_axis_tvalid), .o_normal(w_normal),
        .o_degen(o_m_axis_tuser), .o_last(o_m_axis_tlast)
    );

    assign o_m_axis_tdata = w_normal;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("degenerate face with a non-zero normal");

    a_normal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata != '0)
        else $error("non-degenerate face with a zero normal");

    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");
endmodule
`default_nettype wire
